// ===== sv/gpr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpr_pkg
// Shared types and constants of the grid point registry: command and status
// codes, controller states, store entry layouts and control structs.
// ---------------------------------------------------------------------------
package gpr_pkg;

  localparam int COORD_W  = 6;
  localparam int ID_W     = 10;
  localparam int COUNT_W  = 11;
  localparam int VALUE_W  = 32;
  localparam int ID_DEPTH = 1024;

  // configuration register indexes
  localparam logic REG_GRID_ROWS    = 1'b0;
  localparam logic REG_GRID_COLUMNS = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_CELL = 2'd1,
    CMD_ID   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EXISTS  = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic               used;
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
  } cell_entry_t;

  typedef struct packed {
    logic               used;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } id_entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch;
    logic exec;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

// ===== sv/grid_point_registry.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_point_registry
// Two-way point registry over a rows-by-columns grid, keyed by cell and id.
// ---------------------------------------------------------------------------
// Usage:
//   Drive command, row, column, point_id, auto_id and value_in with start
//   high; the command transfers at the rising edge where start is high and
//   busy is low. Exactly one result follows per command: done is high for
//   one cycle with status, row_out, column_out, id_out and value_out.
//   Add, cell lookup and unknown codes: the stores are read at the transfer
//   edge and written at the next edge, where the result is registered too;
//   busy stays high until then, so a new command transfers only once the
//   block is idle again. Id lookup adds a fetch step, since the cell store
//   is read a second time at the cell that the id store names (one read
//   port per store).
//   The receiver has no stall: a result is present for its single done
//   cycle only.
//   grid_rows (index 0) and grid_columns (index 1) are written through
//   cfg_write/cfg_index/cfg_data while the block is idle; the user must
//   keep to this, the block itself does not enforce it. Reset: rst sets
//   both grid registers to 32 and starts a clearing pass over every entry
//   of both stores; busy stays high in that pass and no command transfers.
// ---------------------------------------------------------------------------
module grid_point_registry #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLUMNS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic [1:0]  command,
  input  logic [5:0]  row,
  input  logic [5:0]  column,
  input  logic [9:0]  point_id,
  input  logic        auto_id,
  input  logic [31:0] value_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  row_out,
  output logic [5:0]  column_out,
  output logic [9:0]  id_out,
  output logic [31:0] value_out
);
  import gpr_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencing
  gpr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (dp_stat),
    .cmd     (dp_cmd),
    .busy    (busy)
  );

  // stores and result logic
  gpr_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (command),
    .row        (row),
    .column     (column),
    .point_id   (point_id),
    .auto_id    (auto_id),
    .value_in   (value_in),
    .done       (done),
    .status     (status),
    .row_out    (row_out),
    .column_out (column_out),
    .id_out     (id_out),
    .value_out  (value_out)
  );

`ifndef SYNTHESIS
  // reset always starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // id lookup answers after its fetch and execute steps
  a_id_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_ID) |-> ##3 done)
    else $error("id lookup result missing");

  // other commands answer after their execute step
  a_cmd_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command != CMD_ID) |-> ##2 done)
    else $error("command result missing");

  // a result only follows a busy cycle
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  // out of range results carry no point
  a_range_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_RANGE) |->
      (row_out == '0 && column_out == '0 && id_out == '0 && value_out == '0))
    else $error("out of range result carries data");
`endif

endmodule

// ===== sv/gpr_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpr_ctrl
// Controller of the grid point registry: clearing pass after reset, command
// accept, optional second store read for id lookup, and execute step.
// ---------------------------------------------------------------------------
module gpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       command,
  input  gpr_pkg::dp_stat_t stat,
  output gpr_pkg::dp_cmd_t  cmd,
  output logic             busy
);
  import gpr_pkg::*;

  ctl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (command == CMD_ID) state_next = S_FETCH;
          else state_next = S_EXEC;
        end
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd.clear  = 1'b0;
    cmd.accept = 1'b0;
    cmd.fetch  = 1'b0;
    cmd.exec   = 1'b0;
    busy       = 1'b1;
    case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_FETCH: cmd.fetch = 1'b1;
      S_EXEC:  cmd.exec  = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== sv/gpr_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpr_datapath
// Datapath of the grid point registry: grid registers, cell and id stores,
// point counter, range checks and the result register.
// ---------------------------------------------------------------------------
module gpr_datapath #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLUMNS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  gpr_pkg::dp_cmd_t  cmd,
  output gpr_pkg::dp_stat_t stat,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [5:0]       cfg_data,
  input  logic [1:0]       command,
  input  logic [5:0]       row,
  input  logic [5:0]       column,
  input  logic [9:0]       point_id,
  input  logic             auto_id,
  input  logic [31:0]      value_in,
  output logic             done,
  output logic [1:0]       status,
  output logic [5:0]       row_out,
  output logic [5:0]       column_out,
  output logic [9:0]       id_out,
  output logic [31:0]      value_out
);
  import gpr_pkg::*;

  localparam int CELL_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int CAW        = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int CLR_DEPTH  = (CELL_DEPTH > ID_DEPTH) ? CELL_DEPTH : ID_DEPTH;
  localparam int CLW        = $clog2(CLR_DEPTH);
  localparam logic [CLW:0]   CELL_DEPTH_C = (CLW+1)'(CELL_DEPTH);
  localparam logic [CLW-1:0] CLR_LAST     = CLW'(CLR_DEPTH - 1);
  localparam logic [8:0]     MAX_ROWS_C   = 9'(MAX_ROWS);
  localparam logic [8:0]     MAX_COLS_C   = 9'(MAX_COLUMNS);

  // flat cell address of a 1-based coordinate pair
  function automatic logic [CAW-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c);
    logic [31:0] wide;
    wide = 32'(r - 6'd1) * 32'(MAX_COLUMNS) + 32'(c - 6'd1);
    return wide[CAW-1:0];
  endfunction

  logic [5:0]          grid_rows, grid_columns;
  logic [COUNT_W-1:0]  point_count;
  logic [CLW-1:0]      clr_cnt;

  cell_entry_t         cell_mem [CELL_DEPTH];
  id_entry_t           id_mem   [ID_DEPTH];
  cell_entry_t         cell_rd, cell_wdata;
  id_entry_t           id_rd, id_wdata;
  logic [CAW-1:0]      cell_raddr, cell_waddr;
  logic [ID_W-1:0]     id_raddr, id_waddr;
  logic                cell_we, id_we;

  logic [1:0]          cmd_q;
  logic [COORD_W-1:0]  row_q, col_q;
  logic [COUNT_W-1:0]  id_q, id_sel;
  logic [VALUE_W-1:0]  val_q;
  logic [CAW-1:0]      ci_q;

  logic [8:0]          eff_rows, eff_cols;
  logic [17:0]         id_limit;
  logic                coord_ok, id_ok, add_ok;
  status_t             res_status;
  logic [COORD_W-1:0]  res_row, res_col;
  logic [ID_W-1:0]     res_id;
  logic [VALUE_W-1:0]  res_val;

  // grid configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= 6'd32;
      grid_columns <= 6'd32;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_ROWS:    grid_rows    <= cfg_data;
        REG_GRID_COLUMNS: grid_columns <= cfg_data;
        default:          grid_rows    <= grid_rows;
      endcase
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign stat.clear_last = (clr_cnt == CLR_LAST);

  // id taken by the incoming command
  assign id_sel = (command == CMD_ADD && auto_id) ? point_count
                                                  : {1'b0, point_id};

  // command capture at transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q <= command;
      row_q <= row;
      col_q <= column;
      id_q  <= id_sel;
      val_q <= value_in;
      ci_q  <= cell_addr(row, column);
    end
  end

  // read addresses: ports at transfer, stored cell of the id when fetching
  assign cell_raddr = cmd.fetch ? cell_addr(id_rd.row, id_rd.col)
                                : cell_addr(row, column);
  assign id_raddr   = cmd.accept ? id_sel[ID_W-1:0] : id_q[ID_W-1:0];

  // range checks
  assign eff_rows = ({3'b0, grid_rows} < MAX_ROWS_C) ? {3'b0, grid_rows} : MAX_ROWS_C;
  assign eff_cols = ({3'b0, grid_columns} < MAX_COLS_C) ? {3'b0, grid_columns} : MAX_COLS_C;
  assign id_limit = eff_rows * eff_cols;
  assign coord_ok = (row_q != '0) && (col_q != '0) &&
                    ({3'b0, row_q} <= eff_rows) && ({3'b0, col_q} <= eff_cols);
  assign id_ok    = ({7'b0, id_q} < id_limit) && !id_q[COUNT_W-1];

  // result of the execute step
  always_comb begin
    add_ok     = 1'b0;
    res_status = STAT_RANGE;
    res_row    = '0;
    res_col    = '0;
    res_id     = '0;
    res_val    = '0;
    case (cmd_q)
      CMD_ADD: begin
        if (coord_ok && id_ok) begin
          if (id_rd.used) begin
            res_status = STAT_EXISTS;
            res_id     = id_q[ID_W-1:0];
          end else begin
            add_ok     = 1'b1;
            res_status = STAT_OK;
            res_row    = row_q;
            res_col    = col_q;
            res_id     = id_q[ID_W-1:0];
            res_val    = val_q;
          end
        end
      end
      CMD_CELL: begin
        if (coord_ok) begin
          if (cell_rd.used) begin
            res_status = STAT_OK;
            res_row    = row_q;
            res_col    = col_q;
            res_id     = cell_rd.id;
            res_val    = cell_rd.value;
          end else begin
            res_status = STAT_MISSING;
          end
        end
      end
      CMD_ID: begin
        if (id_ok) begin
          if (id_rd.used) begin
            res_status = STAT_OK;
            res_row    = id_rd.row;
            res_col    = id_rd.col;
            res_id     = id_q[ID_W-1:0];
            res_val    = cell_rd.value;
          end else begin
            res_status = STAT_MISSING;
          end
        end
      end
      default: res_status = STAT_RANGE;
    endcase
  end

  // store write selection: clearing pass or a successful add
  always_comb begin
    cell_we    = 1'b0;
    id_we      = 1'b0;
    cell_waddr = ci_q;
    id_waddr   = id_q[ID_W-1:0];
    cell_wdata = '{used: 1'b1, id: id_q[ID_W-1:0], value: val_q};
    id_wdata   = '{used: 1'b1, row: row_q, col: col_q};
    if (cmd.clear) begin
      cell_we    = ({1'b0, clr_cnt} < CELL_DEPTH_C);
      id_we      = 1'b1;
      cell_waddr = clr_cnt[CAW-1:0];
      id_waddr   = clr_cnt[ID_W-1:0];
      cell_wdata = '0;
      id_wdata   = '0;
    end else if (cmd.exec && add_ok) begin
      cell_we = 1'b1;
      id_we   = 1'b1;
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_rd <= cell_mem[cell_raddr];
  end

  // id store
  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_waddr] <= id_wdata;
    id_rd <= id_mem[id_raddr];
  end

  // points added so far
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.exec && add_ok) begin
      point_count <= point_count + 1'b1;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= res_status;
      row_out    <= res_row;
      column_out <= res_col;
      id_out     <= res_id;
      value_out  <= res_val;
    end
  end

endmodule

// ===== tb/grid_point_registry_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_point_registry_tb
// Self-checking testbench for the grid point registry. A scoreboard keeps
// its own copy of the cell store, the id store, the point count and the grid
// registers, predicts the result of every command at its transfer, and
// checks each done strobe field by field in order. Stimulus is a directed
// opening and random commands under several grid settings (zero, oversize
// and single-cell grids among them).
// ---------------------------------------------------------------------------
module grid_point_registry_tb;
  import gpr_pkg::*;

  localparam int GRID_ROWS_MAX = 32;
  localparam int GRID_COLS_MAX = 32;
  localparam int CELL_COUNT    = GRID_ROWS_MAX * GRID_COLS_MAX;
  localparam int LIMIT_NS      = 400000;

  // the one command code that the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         command;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [ID_W-1:0]    point_id;
    logic               auto_id;
    logic [VALUE_W-1:0] value_in;
  } cmd_item_t;

  typedef struct {
    status_t            status;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
  } grid_result_t;

  // registry scoreboard: own copy of both stores, predicts and checks
  class registry_scoreboard;
    cell_entry_t        cells [CELL_COUNT];
    id_entry_t          slots [ID_DEPTH];
    logic [COUNT_W-1:0] points_added;
    logic [5:0]         rows_reg;
    logic [5:0]         cols_reg;
    grid_result_t       awaited [$];
    int                 errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (slots[i]) slots[i] = '0;
      points_added = '0;
      rows_reg = 6'd32;
      cols_reg = 6'd32;
      errors = 0;
    endfunction

    function void set_register(logic idx, logic [5:0] d);
      if (idx == REG_GRID_ROWS) rows_reg = d;
      else cols_reg = d;
    endfunction

    function int eff_rows();
      return (int'(rows_reg) < GRID_ROWS_MAX) ? int'(rows_reg) : GRID_ROWS_MAX;
    endfunction

    function int eff_cols();
      return (int'(cols_reg) < GRID_COLS_MAX) ? int'(cols_reg) : GRID_COLS_MAX;
    endfunction

    function bit in_grid(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
      return r >= 1 && c >= 1 && int'(r) <= eff_rows() && int'(c) <= eff_cols();
    endfunction

    function int id_limit();
      int lim;
      lim = eff_rows() * eff_cols();
      return (lim > ID_DEPTH) ? ID_DEPTH : lim;
    endfunction

    // note a transferred command: update the stores, queue its result
    function void note(cmd_item_t it);
      grid_result_t res;
      int           nid;
      int           ci;
      res.status = STAT_RANGE;
      res.row    = '0;
      res.column = '0;
      res.id     = '0;
      res.value  = '0;
      case (it.command)
        CMD_ADD: begin
          nid = it.auto_id ? int'(points_added) : int'(it.point_id);
          if (in_grid(it.row, it.column) && nid < id_limit()) begin
            if (slots[nid].used) begin
              res.status = STAT_EXISTS;
              res.id     = nid[ID_W-1:0];
            end else begin
              ci = (int'(it.row) - 1) * GRID_COLS_MAX + (int'(it.column) - 1);
              cells[ci].used  = 1'b1;
              cells[ci].id    = nid[ID_W-1:0];
              cells[ci].value = it.value_in;
              slots[nid].used = 1'b1;
              slots[nid].row  = it.row;
              slots[nid].col  = it.column;
              points_added++;
              res.status = STAT_OK;
              res.row    = it.row;
              res.column = it.column;
              res.id     = nid[ID_W-1:0];
              res.value  = it.value_in;
            end
          end
        end
        CMD_CELL: begin
          if (in_grid(it.row, it.column)) begin
            ci = (int'(it.row) - 1) * GRID_COLS_MAX + (int'(it.column) - 1);
            if (cells[ci].used) begin
              res.status = STAT_OK;
              res.row    = it.row;
              res.column = it.column;
              res.id     = cells[ci].id;
              res.value  = cells[ci].value;
            end else begin
              res.status = STAT_MISSING;
            end
          end
        end
        CMD_ID: begin
          if (int'(it.point_id) < id_limit()) begin
            if (slots[it.point_id].used) begin
              // the id keeps its cell even when another point took it over
              ci = (int'(slots[it.point_id].row) - 1) * GRID_COLS_MAX
                   + (int'(slots[it.point_id].col) - 1);
              res.status = STAT_OK;
              res.row    = slots[it.point_id].row;
              res.column = slots[it.point_id].col;
              res.id     = it.point_id;
              res.value  = cells[ci].value;
            end else begin
              res.status = STAT_MISSING;
            end
          end
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), res);
    endfunction

    // compare one result transfer against the oldest prediction
    function void check(grid_result_t got);
      grid_result_t want;
      if (awaited.size() == 0) begin
        $error("result with no command pending: status %0d id %0d", got.status, got.id);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("row_out: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
      if (got.column !== want.column) begin
        $error("column_out: expected %0d, got %0d", want.column, got.column);
        errors++;
      end
      if (got.id !== want.id) begin
        $error("id_out: expected %0d, got %0d", want.id, got.id);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value_out: expected %h, got %h", want.value, got.value);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_write;
  logic        cfg_index;
  logic [5:0]  cfg_data;
  logic [1:0]  command;
  logic [5:0]  row;
  logic [5:0]  column;
  logic [9:0]  point_id;
  logic        auto_id;
  logic [31:0] value_in;
  logic        done;
  logic [1:0]  status;
  logic [5:0]  row_out;
  logic [5:0]  column_out;
  logic [9:0]  id_out;
  logic [31:0] value_out;

  registry_scoreboard sb = new();

  grid_point_registry #(
    .MAX_ROWS   (GRID_ROWS_MAX),
    .MAX_COLUMNS(GRID_COLS_MAX)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .row       (row),
    .column    (column),
    .point_id  (point_id),
    .auto_id   (auto_id),
    .value_in  (value_in),
    .done      (done),
    .status    (status),
    .row_out   (row_out),
    .column_out(column_out),
    .id_out    (id_out),
    .value_out (value_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // result monitor: one transfer per done cycle
  always @(posedge clk) begin : result_monitor
    grid_result_t got;
    if (!rst && done) begin
      got.status = status_t'(status);
      got.row    = row_out;
      got.column = column_out;
      got.id     = id_out;
      got.value  = value_out;
      sb.check(got);
    end
  end

  function automatic cmd_item_t mk(logic [1:0] cmd, int r, int c, int pid, bit aut,
                                   logic [31:0] val);
    cmd_item_t it;
    it.command  = cmd;
    it.row      = r[5:0];
    it.column   = c[5:0];
    it.point_id = pid[9:0];
    it.auto_id  = aut;
    it.value_in = val;
    return it;
  endfunction

  // coordinate biased toward a small corner so lookups hit stored points
  function automatic int pick_coord(int lim);
    int p;
    p = $urandom_range(0, 9);
    if (p == 0 || lim == 0) return $urandom_range(0, 63);
    if (p < 6) return $urandom_range(1, (lim < 6) ? lim : 6);
    return $urandom_range(1, lim);
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int        p;
    p = $urandom_range(0, 99);
    if (p < 45)      it.command = CMD_ADD;
    else if (p < 70) it.command = CMD_CELL;
    else if (p < 96) it.command = CMD_ID;
    else             it.command = CMD_UNUSED;
    it.row      = 6'(pick_coord(sb.eff_rows()));
    it.column   = 6'(pick_coord(sb.eff_cols()));
    it.point_id = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 47));
    it.auto_id  = ($urandom_range(0, 3) == 0);
    it.value_in = $urandom;
    return it;
  endfunction

  // drive one command and hold it until it transfers
  task automatic issue(cmd_item_t it);
    @(negedge clk);
    start    = 1'b1;
    command  = it.command;
    row      = it.row;
    column   = it.column;
    point_id = it.point_id;
    auto_id  = it.auto_id;
    value_in = it.value_in;
    do @(posedge clk); while (busy);
    sb.note(it);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // wait until every result is back and the block is idle
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_grid(logic [5:0] rows_val, logic [5:0] cols_val);
    settle();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = REG_GRID_ROWS;
    cfg_data  = rows_val;
    @(negedge clk);
    cfg_index = REG_GRID_COLUMNS;
    cfg_data  = cols_val;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_register(REG_GRID_ROWS, rows_val);
    sb.set_register(REG_GRID_COLUMNS, cols_val);
  endtask

  // random commands in bursts with random gaps
  task automatic run_random(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        issue(random_item());
        burst--;
        left--;
      end
      pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_GRID_ROWS;
    cfg_data  = '0;
    command   = CMD_ADD;
    row       = '0;
    column    = '0;
    point_id  = '0;
    auto_id   = 1'b0;
    value_in  = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed opening on the full grid
    set_grid(6'd32, 6'd32);
    issue(mk(CMD_CELL, 1, 1, $urandom_range(0, 1023), 1'b1, $urandom));
    issue(mk(CMD_ID, 0, 0, 0, 1'b0, $urandom));
    issue(mk(CMD_ADD, 1, 1, 5, 1'b0, 32'h7fff_ffff));
    issue(mk(CMD_ADD, 32, 32, 1023, 1'b0, 32'h8000_0000));
    pause(2);
    issue(mk(CMD_ADD, 2, 3, 5, 1'b0, $urandom));       // id already used
    issue(mk(CMD_ADD, 0, 1, 6, 1'b0, $urandom));       // zero row
    issue(mk(CMD_ADD, 1, 0, 6, 1'b0, $urandom));       // zero column
    issue(mk(CMD_ADD, 33, 1, 6, 1'b0, $urandom));
    issue(mk(CMD_ADD, 63, 63, 6, 1'b0, $urandom));
    // automatic id lands on an occupied cell
    issue(mk(CMD_ADD, 1, 1, 1023, 1'b1, 32'hffff_ffff));
    pause(1);
    issue(mk(CMD_ID, 63, 63, 5, 1'b1, $urandom));
    issue(mk(CMD_CELL, 1, 1, 0, 1'b0, $urandom));
    issue(mk(CMD_CELL, 32, 32, 0, 1'b0, $urandom));
    issue(mk(CMD_ID, 0, 0, 1023, 1'b0, $urandom));
    issue(mk(CMD_UNUSED, 63, 63, 1023, 1'b1, 32'hffff_ffff));
    issue(mk(CMD_CELL, 0, 0, 0, 1'b0, 32'h0));
    pause(3);
    issue(mk(CMD_ADD, 4, 4, 4, 1'b0, 32'h0));
    issue(mk(CMD_ADD, 5, 5, 0, 1'b1, $urandom));       // automatic id already used
    issue(mk(CMD_ADD, 20, 7, 9, 1'b0, 32'h1234_5678));
    issue(mk(CMD_ID, 0, 0, 9, 1'b0, $urandom));
    issue(mk(CMD_CELL, 32, 33, 0, 1'b0, $urandom));

    // single row: points outside the grid are found by id only
    set_grid(6'd1, 6'd32);
    issue(mk(CMD_ID, 0, 0, 9, 1'b0, $urandom));
    issue(mk(CMD_CELL, 20, 7, 0, 1'b0, $urandom));
    issue(mk(CMD_ID, 0, 0, 1023, 1'b0, $urandom));
    issue(mk(CMD_ADD, 1, 1, 32, 1'b0, $urandom));      // id past the grid bound
    run_random(45);

    set_grid(6'd32, 6'd1);
    run_random(45);
    set_grid(6'd1, 6'd1);
    run_random(40);
    set_grid(6'd0, 6'd17);
    run_random(30);
    set_grid(6'd63, 6'd63);
    run_random(50);
    set_grid(6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)));
    run_random(50);
    set_grid(6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)));
    run_random(50);
    set_grid(6'd17, 6'd40);
    run_random(45);

    // back to the full grid for a last mixed stretch
    set_grid(6'd32, 6'd32);
    issue(mk(CMD_ADD, 1, 1, 0, 1'b1, $urandom));
    run_random(20);

    // drain and report
    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gpr_pkg.sv
sv/gpr_ctrl.sv
sv/gpr_datapath.sv
sv/grid_point_registry.sv
tb/grid_point_registry_tb.sv
